[rtl/core/cst_pkg.sv]
package cst_pkg;

    localparam int KEYLEN_WIDTH = 16;
    localparam int KEY_OUT_W    = 16;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam logic [1:0] CFG_AUTH_ONLY = 2'd0;
    localparam logic [1:0] CFG_GROUP_OK  = 2'd1;

    typedef logic [KEYLEN_WIDTH-1:0] key_acc_t;

    typedef enum logic [3:0] {
        ST_START   = 4'd0,
        ST_EA      = 4'd1,
        ST_EA_DASH = 4'd2,
        ST_EK      = 4'd3,
        ST_EK_DASH = 4'd4,
        ST_AA      = 4'd5,
        ST_AA_DASH = 4'd6,
        ST_AK      = 4'd7,
        ST_AK_DASH = 4'd8,
        ST_MODP    = 4'd9,
        ST_STRICT  = 4'd10
    } parse_state_t;

    typedef enum logic [2:0] {
        K_SKIP   = 3'd0,
        K_CIPHER = 3'd1,
        K_HASH   = 3'd2,
        K_GROUP  = 3'd3,
        K_ENTRY  = 3'd4,
        K_EOS    = 3'd5,
        K_FLAG   = 3'd6,
        K_ERROR  = 3'd7
    } kind_t;

    typedef enum logic [3:0] {
        ERR_NONE        = 4'd0,
        ERR_TERM_POS    = 4'd1,
        ERR_START       = 4'd2,
        ERR_EA          = 4'd3,
        ERR_EA_END      = 4'd4,
        ERR_EK          = 4'd5,
        ERR_EK_END      = 4'd6,
        ERR_AA          = 4'd7,
        ERR_AA_END      = 4'd8,
        ERR_AK          = 4'd9,
        ERR_AK_END      = 4'd10,
        ERR_MODP        = 4'd11,
        ERR_STRICT      = 4'd12
    } err_t;

    typedef struct packed {
        kind_t                 kind;
        logic [7:0]            char_out;
        logic [KEY_OUT_W-1:0]  enc_key_bits;
        logic [KEY_OUT_W-1:0]  auth_key_bits;
        err_t                  error_code;
    } result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || is_alpha(c);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // Decimal shift-in of one digit, saturating at the all-ones value.
    function automatic key_acc_t add_digit(input key_acc_t acc, input logic [7:0] c);
        logic [KEYLEN_WIDTH+3:0] v;
        logic [7:0]              d;
        d = c - CH_ZERO;
        v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{(KEYLEN_WIDTH-4){1'b0}}, d};
        if (v[KEYLEN_WIDTH+3:KEYLEN_WIDTH] != 4'b0)
            return '1;
        return v[KEYLEN_WIDTH-1:0];
    endfunction

    function automatic logic [KEY_OUT_W-1:0] key_out(input key_acc_t acc);
        logic [KEYLEN_WIDTH+KEY_OUT_W-1:0] t;
        t = {{KEY_OUT_W{1'b0}}, acc};
        return t[KEY_OUT_W-1:0];
    endfunction

endpackage

[rtl/core/cst_in_reg.sv]
module cst_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] ch,
    input  logic       take,
    output logic       s1_valid,
    output logic [7:0] s1_ch
);
    import cst_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] ch_reg;
    logic       accept;

    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            ch_reg <= ch;
    end

    assign s1_valid = valid_reg;
    assign s1_ch    = ch_reg;

endmodule

[rtl/core/cst_parser.sv]
module cst_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       ch,
    input  logic             auth_only_mode,
    input  logic             group_allowed,
    output cst_pkg::result_t res
);
    import cst_pkg::*;

    parse_state_t st_reg;
    parse_state_t st_next;
    key_acc_t     enc_reg;
    key_acc_t     enc_next;
    key_acc_t     auth_reg;
    key_acc_t     auth_next;
    key_acc_t     enc_dig;
    key_acc_t     auth_dig;
    err_t         err;
    logic         term;
    logic         term_ok;

    assign enc_dig  = add_digit(enc_reg, ch);
    assign auth_dig = add_digit(auth_reg, ch);
    assign term     = (ch == CH_NUL) || (ch == CH_BANG) || (ch == CH_COMMA);
    assign term_ok  = (st_reg == ST_EA) || (st_reg == ST_EK) || (st_reg == ST_AA) ||
                      (st_reg == ST_AK) || (st_reg == ST_MODP) || (st_reg == ST_STRICT);

    always_comb
    begin
        res       = '0;
        res.kind  = K_SKIP;
        res.error_code = ERR_NONE;
        err       = ERR_NONE;
        st_next   = st_reg;
        enc_next  = enc_reg;
        auth_next = auth_reg;
        if (term)
        begin
            if (!term_ok)
                err = ERR_TERM_POS;
            else if (ch == CH_BANG)
            begin
                res.kind = K_FLAG;
                st_next  = ST_STRICT;
            end
            else
            begin
                res.kind          = (ch == CH_NUL) ? K_EOS : K_ENTRY;
                res.enc_key_bits  = key_out(enc_reg);
                res.auth_key_bits = key_out(auth_reg);
                st_next           = ST_START;
                enc_next          = '0;
                auth_next         = '0;
            end
        end
        else
        begin
            unique case (st_reg)
                ST_EA:
                begin
                    if (is_alpha(ch) || ch == CH_UNDER)
                    begin
                        res.kind = K_CIPHER;
                        res.char_out = ch;
                    end
                    else if (is_digit(ch))
                    begin
                        st_next  = ST_EK;
                        enc_next = enc_dig;
                    end
                    else if (ch == CH_DASH)
                        st_next = ST_EA_DASH;
                    else
                        err = ERR_EA;
                end
                ST_EA_DASH:
                begin
                    if (is_digit(ch))
                    begin
                        st_next  = ST_EK;
                        enc_next = enc_dig;
                    end
                    else if (is_alpha(ch))
                    begin
                        st_next  = ST_AA;
                        res.kind = K_HASH;
                        res.char_out = ch;
                    end
                    else
                        err = ERR_EA_END;
                end
                ST_EK:
                begin
                    if (ch == CH_DASH)
                        st_next = ST_EK_DASH;
                    else if (is_digit(ch))
                        enc_next = enc_dig;
                    else
                        err = ERR_EK;
                end
                ST_EK_DASH:
                begin
                    if (is_alpha(ch))
                    begin
                        st_next  = ST_AA;
                        res.kind = K_HASH;
                        res.char_out = ch;
                    end
                    else
                        err = ERR_EK_END;
                end
                ST_AA:
                begin
                    if (ch == CH_DASH)
                        st_next = ST_AA_DASH;
                    else if (is_alnum(ch) || ch == CH_UNDER)
                    begin
                        res.kind = K_HASH;
                        res.char_out = ch;
                    end
                    else
                        err = ERR_AA;
                end
                ST_AA_DASH:
                begin
                    if (is_digit(ch))
                    begin
                        st_next   = ST_AK;
                        auth_next = auth_dig;
                    end
                    else if (group_allowed && is_alpha(ch))
                    begin
                        st_next  = ST_MODP;
                        res.kind = K_GROUP;
                        res.char_out = ch;
                    end
                    else
                        err = ERR_AA_END;
                end
                ST_AK:
                begin
                    if (ch == CH_DASH)
                        st_next = ST_AK_DASH;
                    else if (is_digit(ch))
                        auth_next = auth_dig;
                    else
                        err = ERR_AK;
                end
                ST_AK_DASH:
                begin
                    if (group_allowed && is_alpha(ch))
                    begin
                        st_next  = ST_MODP;
                        res.kind = K_GROUP;
                        res.char_out = ch;
                    end
                    else
                        err = ERR_AK_END;
                end
                ST_MODP:
                begin
                    if (is_alnum(ch))
                    begin
                        res.kind = K_GROUP;
                        res.char_out = ch;
                    end
                    else
                        err = ERR_MODP;
                end
                ST_STRICT:
                    err = ERR_STRICT;
                default:
                begin
                    if (is_alnum(ch))
                    begin
                        res.char_out = ch;
                        if (auth_only_mode)
                        begin
                            res.kind = K_HASH;
                            st_next  = ST_AA;
                        end
                        else
                        begin
                            res.kind = K_CIPHER;
                            st_next  = ST_EA;
                        end
                    end
                    else if (!is_space(ch))
                        err = ERR_START;
                end
            endcase
        end
        if (err != ERR_NONE)
        begin
            res            = '0;
            res.kind       = K_ERROR;
            res.error_code = err;
            st_next        = ST_START;
            enc_next       = '0;
            auth_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_START;
            enc_reg  <= '0;
            auth_reg <= '0;
        end
        else if (step)
        begin
            st_reg   <= st_next;
            enc_reg  <= enc_next;
            auth_reg <= auth_next;
        end
    end

endmodule

[rtl/core/cst_out_reg.sv]
module cst_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  cst_pkg::result_t  res,
    output logic              free,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        kind,
    output logic [7:0]        char_out,
    output logic [15:0]       enc_key_bits,
    output logic [15:0]       auth_key_bits,
    output logic [3:0]        error_code
);
    import cst_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign out_valid     = valid_reg;
    assign kind          = res_reg.kind;
    assign char_out      = res_reg.char_out;
    assign enc_key_bits  = res_reg.enc_key_bits;
    assign auth_key_bits = res_reg.auth_key_bits;
    assign error_code    = res_reg.error_code;

endmodule

[rtl/core/cipher_suite_string_tokenizer.sv]
// Channel   Handshake                  Payload
// input     in_valid / in_stall        ch
// result    out_valid / out_stall      kind, char_out, enc_key_bits, auth_key_bits, error_code
// config    cfg_valid / cfg_ready      cfg_index, cfg_data (bit 0 used)
//
// One item per cycle sustained while out_stall stays low; each item reaches the result port
// through the input register, the parser decode and the result register.
// Reset clears the parse state, both key-length accumulators, the configuration bits
// and all valid flags. A stalled result holds the result register and the parser, and
// in_stall rises in the same cycle whenever the input register holds an item;
// cfg_ready is always high.
module cipher_suite_string_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  ch,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  char_out,
    output logic [15:0] enc_key_bits,
    output logic [15:0] auth_key_bits,
    output logic [3:0]  error_code,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import cst_pkg::*;

    logic       auth_only_reg;
    logic       group_ok_reg;
    logic       s1_valid;
    logic [7:0] s1_ch;
    logic       free;
    logic       take;
    result_t    res;

    assign cfg_ready = 1'b1;
    assign take      = s1_valid && free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auth_only_reg <= 1'b0;
            group_ok_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_AUTH_ONLY)
                auth_only_reg <= cfg_data[0];
            else if (cfg_index == CFG_GROUP_OK)
                group_ok_reg <= cfg_data[0];
        end
    end

    cst_in_reg u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .ch       (ch),
        .take     (take),
        .s1_valid (s1_valid),
        .s1_ch    (s1_ch)
    );

    cst_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (take),
        .ch             (s1_ch),
        .auth_only_mode (auth_only_reg),
        .group_allowed  (group_ok_reg),
        .res            (res)
    );

    cst_out_reg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (take),
        .res           (res),
        .free          (free),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .char_out      (char_out),
        .enc_key_bits  (enc_key_bits),
        .auth_key_bits (auth_key_bits),
        .error_code    (error_code)
    );

endmodule

[verif/cst_token_monitor.sv]
module cst_token_monitor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  ch,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  kind,
    input  logic [7:0]  char_out,
    input  logic [15:0] enc_key_bits,
    input  logic [15:0] auth_key_bits,
    input  logic [3:0]  error_code,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output int          mismatches,
    output int          tokens_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import cst_pkg::*;

    parse_state_t st;
    key_acc_t     enc_acc;
    key_acc_t     auth_acc;
    logic         auth_only;
    logic         group_ok;
    result_t      expected_tokens[$];
    result_t      want;
    int           errs;

    function automatic bit is_dec(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"]};
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c inside {8'd9, 8'd10, 8'd11, 8'd12, 8'd13, " "};
    endfunction

    function automatic key_acc_t shift_in_digit(input key_acc_t acc, input logic [7:0] c);
        longint unsigned v;
        longint unsigned top;
        top = (64'd1 << KEYLEN_WIDTH) - 64'd1;
        v = 64'(acc) * 64'd10 + 64'(c) - 64'(CH_ZERO);
        if (v > top)
            return '1;
        return key_acc_t'(v);
    endfunction

    // Classifies one character and advances the parser copy.
    function automatic result_t classify_char(input logic [7:0] c);
        result_t      r;
        parse_state_t nxt;
        r = '0;
        r.kind = K_SKIP;
        r.error_code = ERR_NONE;
        nxt = st;
        if (c == CH_NUL || c == CH_BANG || c == CH_COMMA)
        begin
            if (!(st inside {ST_EA, ST_EK, ST_AA, ST_AK, ST_MODP, ST_STRICT}))
                r.error_code = ERR_TERM_POS;
            else if (c == CH_BANG)
            begin
                r.kind = K_FLAG;
                nxt = ST_STRICT;
            end
            else
            begin
                if (c == CH_NUL)
                    r.kind = K_EOS;
                else
                    r.kind = K_ENTRY;
                r.enc_key_bits = enc_acc[KEY_OUT_W-1:0];
                r.auth_key_bits = auth_acc[KEY_OUT_W-1:0];
                nxt = ST_START;
                enc_acc = '0;
                auth_acc = '0;
            end
        end
        else
        begin
            case (st)
                ST_EA:
                begin
                    if (is_letter(c) || c == CH_UNDER)
                    begin
                        r.kind = K_CIPHER;
                        r.char_out = c;
                    end
                    else if (is_dec(c))
                    begin
                        nxt = ST_EK;
                        enc_acc = shift_in_digit(enc_acc, c);
                    end
                    else if (c == CH_DASH)
                        nxt = ST_EA_DASH;
                    else
                        r.error_code = ERR_EA;
                end
                ST_EA_DASH:
                begin
                    if (is_dec(c))
                    begin
                        nxt = ST_EK;
                        enc_acc = shift_in_digit(enc_acc, c);
                    end
                    else if (is_letter(c))
                    begin
                        nxt = ST_AA;
                        r.kind = K_HASH;
                        r.char_out = c;
                    end
                    else
                        r.error_code = ERR_EA_END;
                end
                ST_EK:
                begin
                    if (c == CH_DASH)
                        nxt = ST_EK_DASH;
                    else if (is_dec(c))
                        enc_acc = shift_in_digit(enc_acc, c);
                    else
                        r.error_code = ERR_EK;
                end
                ST_EK_DASH:
                begin
                    if (is_letter(c))
                    begin
                        nxt = ST_AA;
                        r.kind = K_HASH;
                        r.char_out = c;
                    end
                    else
                        r.error_code = ERR_EK_END;
                end
                ST_AA:
                begin
                    if (c == CH_DASH)
                        nxt = ST_AA_DASH;
                    else if (is_dec(c) || is_letter(c) || c == CH_UNDER)
                    begin
                        r.kind = K_HASH;
                        r.char_out = c;
                    end
                    else
                        r.error_code = ERR_AA;
                end
                ST_AA_DASH:
                begin
                    if (is_dec(c))
                    begin
                        nxt = ST_AK;
                        auth_acc = shift_in_digit(auth_acc, c);
                    end
                    else if (group_ok && is_letter(c))
                    begin
                        nxt = ST_MODP;
                        r.kind = K_GROUP;
                        r.char_out = c;
                    end
                    else
                        r.error_code = ERR_AA_END;
                end
                ST_AK:
                begin
                    if (c == CH_DASH)
                        nxt = ST_AK_DASH;
                    else if (is_dec(c))
                        auth_acc = shift_in_digit(auth_acc, c);
                    else
                        r.error_code = ERR_AK;
                end
                ST_AK_DASH:
                begin
                    if (group_ok && is_letter(c))
                    begin
                        nxt = ST_MODP;
                        r.kind = K_GROUP;
                        r.char_out = c;
                    end
                    else
                        r.error_code = ERR_AK_END;
                end
                ST_MODP:
                begin
                    if (is_dec(c) || is_letter(c))
                    begin
                        r.kind = K_GROUP;
                        r.char_out = c;
                    end
                    else
                        r.error_code = ERR_MODP;
                end
                ST_STRICT:
                    r.error_code = ERR_STRICT;
                default:
                begin
                    if (is_dec(c) || is_letter(c))
                    begin
                        if (auth_only)
                        begin
                            r.kind = K_HASH;
                            nxt = ST_AA;
                        end
                        else
                        begin
                            r.kind = K_CIPHER;
                            nxt = ST_EA;
                        end
                        r.char_out = c;
                    end
                    else if (!is_blank(c))
                        r.error_code = ERR_START;
                end
            endcase
        end
        if (r.error_code != ERR_NONE)
        begin
            r.kind = K_ERROR;
            r.char_out = '0;
            r.enc_key_bits = '0;
            r.auth_key_bits = '0;
            st = ST_START;
            enc_acc = '0;
            auth_acc = '0;
        end
        else
            st = nxt;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st = ST_START;
            enc_acc = '0;
            auth_acc = '0;
            auth_only = 1'b0;
            group_ok = 1'b0;
            expected_tokens.delete();
            errs = 0;
            mismatches <= 0;
            tokens_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_AUTH_ONLY)
                    auth_only = cfg_data[0];
                else if (cfg_index == CFG_GROUP_OK)
                    group_ok = cfg_data[0];
            end
            if (out_valid && !out_stall)
            begin
                if (expected_tokens.size() == 0)
                begin
                    errs++;
                    $error("unexpected result: kind %0d, char_out %0h", kind, char_out);
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (kind !== want.kind)
                    begin
                        errs++;
                        $error("kind: expected %0d, got %0d", want.kind, kind);
                    end
                    if (char_out !== want.char_out)
                    begin
                        errs++;
                        $error("char_out: expected %0h, got %0h", want.char_out, char_out);
                    end
                    if (enc_key_bits !== want.enc_key_bits)
                    begin
                        errs++;
                        $error("enc_key_bits: expected %0d, got %0d",
                               want.enc_key_bits, enc_key_bits);
                    end
                    if (auth_key_bits !== want.auth_key_bits)
                    begin
                        errs++;
                        $error("auth_key_bits: expected %0d, got %0d",
                               want.auth_key_bits, auth_key_bits);
                    end
                    if (error_code !== want.error_code)
                    begin
                        errs++;
                        $error("error_code: expected %0d, got %0d",
                               want.error_code, error_code);
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_tokens.push_back(classify_char(ch));
            mismatches <= errs;
            tokens_pending <= expected_tokens.size();
        end
    end

endmodule

[verif/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cst_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd2;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 150;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  ch = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  char_out;
    logic [15:0] enc_key_bits;
    logic [15:0] auth_key_bits;
    logic [3:0]  error_code;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [7:0]  cfg_data = 8'd0;

    int mismatches;
    int tokens_pending;
    int cycles = 0;
    int n_items = 0;
    int n_settings = 1;
    bit calm = 1'b0;
    bit mode_ah = 1'b0;
    bit mode_group = 1'b0;

    cipher_suite_string_tokenizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .ch            (ch),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .char_out      (char_out),
        .enc_key_bits  (enc_key_bits),
        .auth_key_bits (auth_key_bits),
        .error_code    (error_code),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    cst_token_monitor token_mon (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .ch             (ch),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .char_out       (char_out),
        .enc_key_bits   (enc_key_bits),
        .auth_key_bits  (auth_key_bits),
        .error_code     (error_code),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .tokens_pending (tokens_pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < 25);

    task automatic push_char(input logic [7:0] c);
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 25)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        ch <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    // Occasionally slips a random byte in ahead of the intended character.
    task automatic emit(input logic [7:0] c);
        if ($urandom_range(0, 99) < 3)
            push_char(8'($urandom_range(0, 255)));
        push_char(c);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tokens_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input bit val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= {7'($urandom), val};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        if (r < 26)
            return 8'("a" + r);
        return 8'("A" + r - 26);
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_alnum();
        if ($urandom_range(0, 4) == 0)
            return rand_digit();
        return rand_letter();
    endfunction

    function automatic logic [7:0] rand_blank();
        int r;
        r = $urandom_range(0, 5);
        if (r == 5)
            return " ";
        return 8'(9 + r);
    endfunction

    task automatic send_number();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
        repeat (n) emit(rand_digit());
    endtask

    task automatic send_entry();
        int path;
        int r;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) emit(rand_blank());
        if (!mode_ah)
        begin
            emit(rand_alnum());
            repeat ($urandom_range(0, 4))
                emit(($urandom_range(0, 5) == 0) ? CH_UNDER : rand_letter());
            path = $urandom_range(0, 2);
            if (path != 2)
            begin
                if (path == 1)
                    emit(CH_DASH);
                send_number();
            end
            emit(CH_DASH);
            emit(rand_letter());
        end
        else
            emit(rand_alnum());
        repeat ($urandom_range(0, 4))
            emit(($urandom_range(0, 5) == 0) ? CH_UNDER : rand_alnum());
        if ($urandom_range(0, 1) == 1)
        begin
            emit(CH_DASH);
            send_number();
        end
        if (mode_group ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 9) == 0))
        begin
            emit(CH_DASH);
            emit(rand_letter());
            repeat ($urandom_range(0, 5)) emit(rand_alnum());
        end
        r = $urandom_range(0, 9);
        if (r < 6)
            emit(CH_COMMA);
        else if (r < 8)
            emit(CH_NUL);
        else
        begin
            emit(CH_BANG);
            emit(($urandom_range(0, 1) == 1) ? CH_COMMA : CH_NUL);
        end
    endtask

    initial
    begin
        bit [3:0] ah_seq;
        bit [3:0] group_seq;
        int target;
        bit paused;
        ah_seq = 4'b0110;
        group_seq = 4'b0011;
        paused = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("\t3des99999-md5-7,");
        push_char(8'hFF);
        push_char(CH_NUL);
        send_text("a!x");
        send_text("b!");
        push_char(CH_NUL);

        for (int p = 0; p < 4; p++)
        begin
            drain();
            mode_ah = ah_seq[p];
            mode_group = group_seq[p];
            write_reg(CFG_AUTH_ONLY, mode_ah);
            write_reg(CFG_GROUP_OK, mode_group);
            if (p == 0)
                write_reg(CFG_SPARE, 1'($urandom));
            n_settings++;
            calm = (p == 2);
            target = n_items + PHASE_ITEMS;
            while (n_items < target)
            begin
                send_entry();
                if (p == 1 && !paused && n_items > target - PHASE_ITEMS / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
            end
        end
        drain();

        $display("Ran %0d characters through %0d register settings (ESP/AH, group on/off),",
                 n_items, n_settings);
        $display("with random gaps and stalls on both channels and one fully busy phase.");
        if (mismatches == 0 && tokens_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
